/* rtl/core/msf_pkg.sv */
// ----------------------------------------------------------------------------
// msf_pkg
// Shared defaults and controller/datapath interface types for the monotonic
// stack filter.
// ----------------------------------------------------------------------------
package msf_pkg;

    // Default sizing
    localparam int MSF_DEPTH       = 64;
    localparam int MSF_VALUE_WIDTH = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;    // capture the input transaction
        logic pop;       // drop top entry, fetch the one below it
        logic load_top;  // take fetched entry as the new top
        logic push;      // write held value on top of the stack
        logic set_ovf;   // mark a dropped push
        logic dump_rd;   // read the next entry of the dump
        logic dump_ld;   // move read entry into the output register
        logic clear;     // empty the stack and the overflow flag
    } msf_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;      // stack holds no entry
        logic full;       // stack holds DEPTH entries
        logic top_ge;     // top entry >= held value (signed)
        logic last_item;  // held value ends the sequence
        logic dump_last;  // entry being loaded is the topmost one
        logic out_free;   // output register can take an entry next cycle
    } msf_status_t;

endpackage

/* rtl/core/msf_ram.sv */
// ----------------------------------------------------------------------------
// msf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/core/msf_ctrl.sv */
// ----------------------------------------------------------------------------
// msf_ctrl
// Sequencer for the stack filter: accept, compare/pop, push, and dump.
// ----------------------------------------------------------------------------
module msf_ctrl
    import msf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  msf_status_t status,
    output msf_cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CMP  = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DRD  = 5'b01000,
        ST_DLD  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (!status.empty && status.top_ge)
                begin
                    cmd.pop    = 1'b1;
                    state_next = ST_LOAD;
                end
                else
                begin
                    cmd.push    = !status.full;
                    cmd.set_ovf = status.full;
                    state_next  = status.last_item ? ST_DRD : ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                cmd.load_top = 1'b1;
                state_next   = ST_CMP;
            end
            ST_DRD:
            begin
                // issue a read only once the output register will be free
                if (status.out_free)
                begin
                    cmd.dump_rd = 1'b1;
                    state_next  = ST_DLD;
                end
            end
            ST_DLD:
            begin
                cmd.dump_ld = 1'b1;
                if (status.dump_last)
                begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/msf_dp.sv */
// ----------------------------------------------------------------------------
// msf_dp
// Datapath: held input, top-of-stack register, stack RAM, count, overflow
// flag, dump index and output register.
// ----------------------------------------------------------------------------
module msf_dp
    import msf_pkg::*;
#(
    parameter int DEPTH       = MSF_DEPTH,
    parameter int VALUE_WIDTH = MSF_VALUE_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  msf_cmd_t               cmd,
    output msf_status_t            status,
    input  logic [VALUE_WIDTH-1:0] in_value,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [VALUE_WIDTH-1:0] out_value,
    output logic                   out_final,
    output logic                   out_ovf
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   last_reg;
    logic [VALUE_WIDTH-1:0] top_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          idx_reg;
    logic                   ovf_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic                   out_final_reg;
    logic                   out_ovf_reg;

    logic [CW-1:0]          count_minus2;
    logic [AW-1:0]          rd_addr;
    logic                   rd_en;
    logic [VALUE_WIDTH-1:0] rd_data;

    // Read address: entry below the top on a pop, dump index otherwise
    assign count_minus2 = count_reg - CW'(2);
    assign rd_addr      = cmd.pop ? count_minus2[AW-1:0] : idx_reg[AW-1:0];
    assign rd_en        = cmd.pop | cmd.dump_rd;

    msf_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (val_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Held input transaction and top of stack
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            val_reg  <= in_value;
            last_reg <= in_last;
        end
        if (cmd.push)
        begin
            top_reg <= val_reg;
        end
        else if (cmd.load_top)
        begin
            top_reg <= rd_data;
        end
    end

    // Count, dump index, overflow flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                idx_reg   <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                if (cmd.pop)
                begin
                    count_reg <= count_reg - CW'(1);
                end
                else if (cmd.push)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                if (cmd.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
                if (cmd.dump_rd)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.dump_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.dump_ld)
        begin
            out_value_reg <= rd_data;
            out_final_reg <= status.dump_last;
            out_ovf_reg   <= ovf_reg;
        end
    end

    // Status to the controller
    always_comb
    begin
        status.empty     = (count_reg == '0);
        status.full      = (count_reg == CW'(DEPTH));
        status.top_ge    = ($signed(top_reg) >= $signed(val_reg));
        status.last_item = last_reg;
        status.dump_last = (idx_reg == count_reg);
        status.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign out_final = out_final_reg;
    assign out_ovf   = out_ovf_reg;

endmodule

/* rtl/core/monotonic_stack_filter.sv */
// ----------------------------------------------------------------------------
// monotonic_stack_filter
// Keeps a strictly increasing stack of signed values and dumps it at the end
// of each sequence.
// ----------------------------------------------------------------------------
// Each input transaction carries one signed value; entries on top of the stack
// that are greater than or equal to it are popped, then the value is pushed.
// A push into a full stack is dropped and sets a sticky overflow flag. On the
// transaction marked tlast the stack is sent out bottom to top, the topmost
// entry marked tlast and every entry carrying the overflow flag in tuser; the
// stack and flag are then cleared. Items are handled one at a time: each
// popped entry and each emitted dump entry needs its own read of the stack
// RAM, whose single read port is registered, and the dump waits while the
// output is stalled. No clearing pass is needed after reset; a new item can
// be taken while the last dump entry is still waiting at the output.
// ----------------------------------------------------------------------------
module monotonic_stack_filter
    import msf_pkg::*;
#(
    parameter int DEPTH       = MSF_DEPTH,
    parameter int VALUE_WIDTH = MSF_VALUE_WIDTH,
    localparam int TDATA_W    = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value, rest zero
    input  logic               s_tlast,   // end_of_sequence
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [VALUE_WIDTH-1:0] stack_entry, rest zero
    output logic               m_tlast,   // final_entry
    output logic               m_tuser    // [0] overflowed
);

    msf_cmd_t               cmd;
    msf_status_t            status;
    logic [VALUE_WIDTH-1:0] out_value;

    msf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    msf_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_value  (s_tdata[VALUE_WIDTH-1:0]),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_value (out_value),
        .out_final (m_tlast),
        .out_ovf   (m_tuser)
    );

    assign m_tdata = TDATA_W'(out_value);

    // A dump entry is only loaded into a free output register
    a_dump_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_ld |-> !m_tvalid)
        else $error("dump entry loaded over a pending output transaction");

    // No pop on an empty stack
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !status.empty)
        else $error("pop issued on empty stack");

    // Input is only taken while no stack operation is under way
    a_ready_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.pop || cmd.push || cmd.load_top || cmd.dump_ld))
        else $error("input ready during stack operation");

    // A finished pop is always followed by loading the new top
    a_pop_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> cmd.load_top)
        else $error("pop not followed by top reload");

endmodule

/* sim/monotonic_stack_filter_tb.sv */
// ----------------------------------------------------------------------------
// monotonic_stack_filter_tb
// Self-checking bench for the monotonic stack filter.
// ----------------------------------------------------------------------------
// Value sequences are streamed into the slave side from a queue of pending
// transactions. A cycle-free model of the increasing stack tracks every
// accepted transaction and queues the dump it must produce. Each dump entry
// on the master side is checked against that queue. The run covers directed
// corner sequences first, then random sequences under several idle and stall
// mixes, and ends with a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module monotonic_stack_filter_tb
    import msf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = MSF_DEPTH;
    localparam int VW         = MSF_VALUE_WIDTH;
    localparam int CYCLE_CAP  = 300000;
    localparam int HOLD_LEN   = 400;
    localparam int MAX_REPORT = 10;

    localparam logic [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    // One pending input transaction
    typedef struct {
        logic [VW-1:0] value;
        logic          eos;
    } sample_t;

    // One expected dump entry
    typedef struct {
        logic [VW-1:0] entry;
        logic          is_top;
        logic          ovf;
    } dump_entry_t;

    logic          clk      = 1'b0;
    logic          rst_n    = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [VW-1:0] s_tdata  = '0;
    logic          s_tlast  = 1'b0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [VW-1:0] m_tdata;
    logic          m_tlast;
    logic          m_tuser;

    sample_t     feed_q[$];
    dump_entry_t dump_q[$];
    sample_t     drv_item;
    idle_mode_t  idle_mode = IDLE_NONE;

    // Stack model state
    logic signed [VW-1:0] stk [DEPTH];
    int                   stk_cnt = 0;
    logic                 stk_ovf = 1'b0;

    int   errors    = 0;
    int   cycles    = 0;
    int   hold_left = 0;
    logic hold_go   = 1'b0;
    logic hold_done = 1'b0;

    monotonic_stack_filter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    function automatic bit sender_gap();
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 79 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        return $urandom_range(99) < pct;
    endfunction

    function automatic bit receiver_stall();
        int pct;
        pct = (idle_mode == IDLE_RECEIVER) ? 79 : (idle_mode == IDLE_BOTH) ? 6 : 0;
        return $urandom_range(99) < pct;
    endfunction

    // Pop every entry >= value, push it if room is left, dump on end of sequence
    task automatic track_item(input logic [VW-1:0] v, input logic eos);
        dump_entry_t e;
        while (stk_cnt > 0 && stk[stk_cnt-1] >= $signed(v))
            stk_cnt--;
        if (stk_cnt < DEPTH)
        begin
            stk[stk_cnt] = v;
            stk_cnt++;
        end
        else
        begin
            stk_ovf = 1'b1;
        end
        if (eos)
        begin
            for (int k = 0; k < stk_cnt; k++)
            begin
                e.entry  = stk[k];
                e.is_top = (k == stk_cnt - 1);
                e.ovf    = stk_ovf;
                dump_q   = {dump_q, e};
            end
            stk_cnt = 0;
            stk_ovf = 1'b0;
        end
    endtask

    task automatic check_result();
        dump_entry_t e;
        if (dump_q.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORT)
                $display("[%0t] unexpected result: entry %h last %b ovf %b",
                         $realtime, m_tdata, m_tlast, m_tuser);
        end
        else
        begin
            e = dump_q.pop_front();
            if (m_tdata !== e.entry || m_tlast !== e.is_top || m_tuser !== e.ovf)
            begin
                errors++;
                if (errors <= MAX_REPORT)
                    $display("[%0t] mismatch: expected entry %h last %b ovf %b, got %h %b %b",
                             $realtime, e.entry, e.is_top, e.ovf, m_tdata, m_tlast, m_tuser);
            end
        end
    endtask

    // Driver: offer the next pending transaction once the current one is taken
    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (feed_q.size() != 0 && !sender_gap())
            begin
                drv_item = feed_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_item.value;
                s_tlast  <= drv_item.eos;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: track accepted inputs, check accepted outputs, pace m_tready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                track_item(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_result();
            m_tready <= (hold_left == 0) && !receiver_stall();
        end
    end

    // Long output hold-off, started once
    always @(posedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("** monotonic_stack_filter: FAILED **");
            $finish;
        end
    end

    task automatic put(input logic [VW-1:0] v, input logic eos);
        sample_t s;
        s.value = v;
        s.eos   = eos;
        feed_q  = {feed_q, s};
    endtask

    function automatic logic [VW-1:0] rand_value();
        int sel;
        int sv;
        sel = $urandom_range(0, 7);
        sv  = int'($urandom_range(0, 8)) - 4;
        case (sel)
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2, 3:    return VW'(sv);
            default: return VW'($urandom);
        endcase
    endfunction

    // Random sequence: long increasing run (often overflowing), short
    // small-range sequence full of ties, or wide-range noise
    task automatic add_sequence(output int len);
        int                   kind;
        logic signed [VW-1:0] v;
        logic                 eos;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            len = $urandom_range(60, 72);
            v = ($urandom_range(0, 3) == 0) ? $signed(VAL_MIN) : $signed(VW'($urandom)) >>> 8;
            for (int i = 0; i < len; i++)
            begin
                eos = (i == len - 1);
                if (eos && $urandom_range(0, 2) == 0)
                    put(rand_value(), eos);
                else
                    put(v, eos);
                v = v + $urandom_range(1, 1000);
            end
        end
        else
        begin
            len = (kind < 7) ? $urandom_range(1, 8) : $urandom_range(1, 20);
            for (int i = 0; i < len; i++)
            begin
                if (kind < 7)
                    put(VW'(int'($urandom_range(0, 8)) - 4), i == len - 1);
                else
                    put(rand_value(), i == len - 1);
            end
        end
    endtask

    task automatic add_random(input int target);
        int added;
        int len;
        added = 0;
        while (added < target)
        begin
            add_sequence(len);
            added += len;
        end
    endtask

    // Wait until every pending transaction is sent and every dump has arrived
    task automatic drain();
        while (feed_q.size() != 0 || s_tvalid || dump_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: extremes, tie pops, full pop-down, single-item sequence
        idle_mode = IDLE_NONE;
        put(32'sd0, 1'b0);
        put(-32'sd1, 1'b0);
        put(VAL_MAX, 1'b0);
        put(VAL_MIN, 1'b0);
        put(32'sd5, 1'b1);
        put(VAL_MAX, 1'b1);
        put(-32'sd3, 1'b0);
        put(-32'sd2, 1'b0);
        put(-32'sd1, 1'b0);
        put(32'sd0, 1'b0);
        put(32'sd1, 1'b0);
        put(32'sd1, 1'b1);
        put(32'sd100, 1'b0);
        put(32'sd50, 1'b0);
        put(32'sd10, 1'b0);
        put(VAL_MIN, 1'b1);
        put(32'sd7, 1'b0);
        put(32'sd7, 1'b0);
        put(32'sd7, 1'b0);
        put(32'sd7, 1'b1);
        put(VAL_MIN, 1'b0);
        put(VAL_MAX, 1'b1);
        drain();

        // Random sequences under each idle mix
        for (int m = 0; m < 4; m++)
        begin
            idle_mode = idle_mode_t'(m);
            add_random(70);
            drain();
        end

        // Output held off while input keeps coming
        idle_mode = IDLE_NONE;
        hold_go   = 1'b1;
        add_random(30);
        drain();

        repeat (20) @(posedge clk);
        if (errors == 0 && dump_q.size() == 0)
            $display("** monotonic_stack_filter: PASSED **");
        else
            $display("** monotonic_stack_filter: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/msf_pkg.sv
rtl/core/msf_ram.sv
rtl/core/msf_ctrl.sv
rtl/core/msf_dp.sv
rtl/core/monotonic_stack_filter.sv
sim/monotonic_stack_filter_tb.sv
